/* rtl/pcgnl_pkg.sv */
// shared constants, types and tables for the periodic cell grid lookup
package pcgnl_pkg;
  localparam int GRID_SIDE_DEF = 16;
  localparam int COORD_W = 16;
  localparam int IDX_W = 16;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_CELLS_X = 3'd0,
    REG_CELLS_Y = 3'd1,
    REG_CELLS_Z = 3'd2,
    REG_SCALE_X = 3'd3,
    REG_SCALE_Y = 3'd4,
    REG_SCALE_Z = 3'd5,
    REG_BOX     = 3'd6,
    REG_RADIUS  = 3'd7
  } reg_idx_t;

  // q0.16 reciprocal of the sub-box scale, index is the scale
  function automatic logic [15:0] inv_scale(input logic [3:0] s);
    logic [15:0] r;
    case (s)
      4'd1: r = 16'd65535;
      4'd2: r = 16'd32768;
      4'd3: r = 16'd21845;
      4'd4: r = 16'd16384;
      4'd5: r = 16'd13107;
      4'd6: r = 16'd10923;
      4'd7: r = 16'd9362;
      4'd8: r = 16'd8192;
      4'd9: r = 16'd7282;
      4'd10: r = 16'd6554;
      4'd11: r = 16'd5958;
      4'd12: r = 16'd5461;
      4'd13: r = 16'd5041;
      4'd14: r = 16'd4681;
      4'd15: r = 16'd4369;
      default: r = 16'd65535;
    endcase
    return r;
  endfunction
endpackage

/* rtl/pcgnl_ram.sv */
// generic single-port ram with registered read
module pcgnl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/pcgnl_mac.sv */
// shared multiplier: one registered product per cycle
module pcgnl_mac (
  input  logic        clk,
  input  logic [23:0] a,
  input  logic [23:0] b,
  output logic [47:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

/* rtl/periodic_cell_grid_neighbor_lookup_core.sv */
// periodic cell grid: clear, insert, read and neighbor lookup over one cell memory
// Each transaction on s_axis gives one result on m_axis. The block takes one item at a
// time: s_axis_tready is high only while idle and stays low from the accept until the
// result is taken. Every item other than clear first finds its home cell: per axis one
// product through the shared multiplier, then one compare-and-subtract per cycle for the
// wrap (floor(coord*scale) subtracts, at most 14). Insert and read then take one read of
// the cell memory; insert also writes the atom and its coordinates into that cell.
// A lookup visits up to 27 neighbor cells one after another through the single memory
// port, with one memory read for an empty cell and one memory read and seven products
// through the one shared multiplier for an occupied one. Clear sweeps all entries of the
// cell memory, 2^(3*ceil(log2 GRID_SIDE)) of them (4096 at the default), one per cycle;
// after reset the same clearing pass runs before the first item is accepted.
// A stalled m_axis holds the block until the result is taken.
module periodic_cell_grid_neighbor_lookup_core #(
  parameter int GRID_SIDE = pcgnl_pkg::GRID_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // atom_index[15:0], coord_x[31:16], coord_y[47:32], coord_z[63:48]
  input  logic [63:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // found[0], result_index[16:1], zero [23:17]
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  localparam int SW = $clog2(GRID_SIDE) > 0 ? $clog2(GRID_SIDE) : 1;
  localparam int AW = 3 * SW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HOME, S_CELL, S_MOD, S_ADDR, S_RD, S_RDW, S_MUL, S_ACC, S_OUT
  } state_t;

  state_t state;
  logic [4:0] cells [3];
  logic [3:0] scale [3];
  logic [47:0] box;
  logic [15:0] radius;

  logic [1:0]  kind;
  logic [15:0] atom;
  logic [15:0] crd [3];
  logic [SW-1:0] home [3];
  logic [SW-1:0] nb [3];
  logic [1:0]  off [3];
  logic [1:0]  ax;
  logic [2:0]  ph;
  logic [AW:0] sweep;
  logic        found;
  logic [15:0] ridx;
  logic [47:0] sumsq;
  logic [23:0] dl;
  logic [7:0]  rem;

  logic [4:0] ecells [3];
  logic [3:0] escale [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ecells[a] = (cells[a] == 5'd0) ? 5'd1 :
                  (int'(cells[a]) > GRID_SIDE) ? 5'(GRID_SIDE) : cells[a];
      escale[a] = (scale[a] == 4'd0) ? 4'd1 : scale[a];
    end
  end

  // memories
  logic          we;
  logic [AW-1:0] addr;
  logic [16:0]   occ_w, occ_r;
  logic [47:0]   crd_w, crd_r;
  pcgnl_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_occ (
    .clk(clk), .we(we), .addr(addr), .wdata(occ_w), .rdata(occ_r));
  pcgnl_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_crd (
    .clk(clk), .we(we), .addr(addr), .wdata(crd_w), .rdata(crd_r));

  // shared multiplier
  logic [23:0] ma, mb;
  logic [47:0] mp;
  pcgnl_mac u_mac (.clk(clk), .a(ma), .b(mb), .p(mp));

  // per-axis folded distance, from stored coord of the current axis
  logic [15:0] q_ax, p_ax, dd, df;
  logic [16:0] d1;
  logic [19:0] ds;
  logic [15:0] inv;
  always_comb begin
    p_ax = crd[ax];
    q_ax = crd_r[16*ax +: 16];
    dd = (p_ax > q_ax) ? p_ax - q_ax : q_ax - p_ax;
    d1 = (dd >= 16'h8000) ? 17'h10000 - {1'b0, dd} : {1'b0, dd};
    ds = d1 * escale[ax];
    inv = pcgnl_pkg::inv_scale(escale[ax]);
    if (ds > 20'h8000) begin
      df = ({1'b0, inv} >= d1) ? 16'({1'b0, inv} - d1) : 16'(d1 - {1'b0, inv});
    end else begin
      df = d1[15:0];
    end
  end

  logic [AW-1:0] nb_addr;
  assign nb_addr = {nb[0], nb[1], nb[2]};

  // neighbor cell with wrap
  logic [5:0] nsum;
  always_comb begin
    nsum = 6'(home[ax]) + 6'(ecells[ax]) - 6'd1 + 6'(off[ax]);
    if (nsum >= 6'(ecells[ax])) nsum = nsum - 6'(ecells[ax]);
    if (nsum >= 6'(ecells[ax])) nsum = nsum - 6'(ecells[ax]);
  end

  always_comb begin
    ma = 24'd0;
    mb = 24'd0;
    case (state)
      S_HOME: begin
        ma = {8'd0, crd[ax]};
        mb = {20'd0, escale[ax]} * {19'd0, ecells[ax]};
      end
      S_MUL: begin
        if (ph == 3'd0) begin
          ma = {8'd0, df};
          mb = {8'd0, box[16*ax +: 16]};
        end else begin
          ma = dl;
          mb = dl;
        end
      end
      S_ACC: begin
        ma = {radius, 8'd0};
        mb = {radius, 8'd0};
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {7'd0, ridx, found};

  always_comb begin
    we = 1'b0;
    addr = nb_addr;
    occ_w = {1'b1, atom};
    crd_w = {crd[2], crd[1], crd[0]};
    if (state == S_INIT) begin
      we = 1'b1;
      addr = sweep[AW-1:0];
      occ_w = 17'd0;
    end else if (state == S_RDW && kind == pcgnl_pkg::KIND_INSERT) begin
      we = 1'b1;
    end
  end

  logic [47:0] tot;
  assign tot = sumsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      sweep <= '0;
      ph <= 3'd0;
      for (int a = 0; a < 3; a++) begin
        cells[a] <= 5'd1;
        scale[a] <= 4'd1;
      end
      box <= '0;
      radius <= '0;
    end else begin
      if (cfg_valid) begin
        case (pcgnl_pkg::reg_idx_t'(cfg_index))
          pcgnl_pkg::REG_CELLS_X: cells[0] <= cfg_data[4:0];
          pcgnl_pkg::REG_CELLS_Y: cells[1] <= cfg_data[4:0];
          pcgnl_pkg::REG_CELLS_Z: cells[2] <= cfg_data[4:0];
          pcgnl_pkg::REG_SCALE_X: scale[0] <= cfg_data[3:0];
          pcgnl_pkg::REG_SCALE_Y: scale[1] <= cfg_data[3:0];
          pcgnl_pkg::REG_SCALE_Z: scale[2] <= cfg_data[3:0];
          pcgnl_pkg::REG_BOX:     box <= cfg_data;
          pcgnl_pkg::REG_RADIUS:  radius <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        S_INIT: begin
          sweep <= sweep + 1'b1;
          // ph 7 marks a clear transaction, which owes a result
          if (sweep == (AW+1)'(DEPTH - 1)) state <= (ph == 3'd7) ? S_OUT : S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            kind <= s_axis_tuser;
            atom <= s_axis_tdata[15:0];
            crd[0] <= s_axis_tdata[31:16];
            crd[1] <= s_axis_tdata[47:32];
            crd[2] <= s_axis_tdata[63:48];
            found <= 1'b0;
            ridx <= '0;
            ax <= 2'd0;
            ph <= 3'd0;
            if (s_axis_tuser == pcgnl_pkg::KIND_CLEAR) begin
              sweep <= '0;
              ph <= 3'd7;
              state <= S_INIT;
            end else begin
              state <= S_HOME;
            end
          end
        end
        S_HOME: begin
          // product lands next cycle
          state <= S_CELL;
        end
        S_CELL: begin
          rem <= mp[23:16];
          state <= S_MOD;
        end
        S_MOD: begin
          // floor(coord*scale*cells) mod cells, one subtract per cycle
          if (rem >= {3'd0, ecells[ax]}) begin
            rem <= rem - {3'd0, ecells[ax]};
          end else begin
            home[ax] <= SW'(rem);
            if (ax == 2'd2) begin
              ax <= 2'd0;
              // lookup starts at offset -1, insert and read use the home cell
              for (int a = 0; a < 3; a++)
                off[a] <= (kind == pcgnl_pkg::KIND_LOOKUP) ? 2'd0 : 2'd1;
              state <= S_ADDR;
            end else begin
              ax <= ax + 2'd1;
              state <= S_HOME;
            end
          end
        end
        S_ADDR: begin
          // one axis of the neighbor address per cycle
          nb[ax] <= SW'(nsum);
          if (ax == 2'd2) begin
            ax <= 2'd0;
            state <= S_RD;
          end else begin
            ax <= ax + 2'd1;
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          if (kind != pcgnl_pkg::KIND_LOOKUP) begin
            found <= occ_r[16];
            ridx <= occ_r[16] ? occ_r[15:0] : 16'd0;
            state <= S_OUT;
          end else if (!occ_r[16]) begin
            state <= S_ACC;
            ph <= 3'd7;
          end else begin
            sumsq <= '0;
            ax <= 2'd0;
            ph <= 3'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // ph 0 issue d*len, 1 capture, 2 issue square, 3 accumulate
          case (ph)
            3'd0: ph <= 3'd1;
            3'd1: begin
              dl <= mp[31:8];
              ph <= 3'd2;
            end
            3'd2: ph <= 3'd3;
            3'd3: begin
              sumsq <= sumsq + mp;
              if (ax == 2'd2) begin
                ph <= 3'd0;
                state <= S_ACC;
              end else begin
                ax <= ax + 2'd1;
                ph <= 3'd0;
              end
            end
            default: ph <= 3'd0;
          endcase
        end
        S_ACC: begin
          // ph 7 means empty cell; else wait for radius square
          if (ph == 3'd0) begin
            ph <= 3'd1;
          end else begin
            if (ph == 3'd1 && tot < mp) begin
              found <= 1'b1;
              ridx <= occ_r[15:0];
              state <= S_OUT;
            end else begin
              ax <= 2'd0;
              ph <= 3'd0;
              if (off[2] != 2'd2) begin
                off[2] <= off[2] + 2'd1;
                state <= S_ADDR;
              end else if (off[1] != 2'd2) begin
                off[2] <= 2'd0;
                off[1] <= off[1] + 2'd1;
                state <= S_ADDR;
              end else if (off[0] != 2'd2) begin
                off[2] <= 2'd0;
                off[1] <= 2'd0;
                off[0] <= off[0] + 2'd1;
                state <= S_ADDR;
              end else begin
                state <= S_OUT;
              end
            end
          end
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
